// ===== sv/jcd_pkg.sv =====
`default_nettype none
package jcd_pkg;

	typedef enum logic [3:0] {
		PH_PREFIX  = 4'b0001,
		PH_RANGE   = 4'b0010,
		PH_AMBIG   = 4'b0100,
		PH_DECIDED = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		V_MAYBE = 2'd0,
		V_YES   = 2'd1,
		V_NO    = 2'd2
	} verdict_t;

	localparam logic [2:0] CS_PLAIN     = 3'd0;
	localparam logic [2:0] CS_JIS       = 3'd1;
	localparam logic [2:0] CS_SJIS      = 3'd2;
	localparam logic [2:0] CS_EUC       = 3'd3;
	localparam logic [2:0] CS_UNDECIDED = 3'd4;

	// escape sequence progress
	localparam logic [2:0] ESC_NONE   = 3'd0;
	localparam logic [2:0] ESC_ONE    = 3'd1;
	localparam logic [2:0] ESC_DOLLAR = 3'd2;
	localparam logic [2:0] ESC_PAREN  = 3'd3;
	localparam logic [2:0] ESC_DOLPAR = 3'd4;

	localparam logic [1:0] EUC_KANA  = 2'd0;
	localparam logic [1:0] EUC_SS3   = 2'd1;
	localparam logic [1:0] EUC_PLAIN = 2'd2;
	localparam logic [1:0] EUC_ONLY  = 2'd3;

	localparam logic [1:0] DCS_SJIS = 2'd1;
	localparam logic [1:0] DCS_EUC  = 2'd2;

	localparam logic CFG_DEFAULT_CHARSET = 1'b0;
	localparam logic CFG_TIE_PICK        = 1'b1;

	typedef struct packed {
		logic hi;
		logic is_80;
		logic is_8e;
		logic is_8f;
		logic is_a0;
		logic is_ff;
		logic is_esc;
		logic is_dollar;
		logic is_paren;
		logic is_b_at;
		logic is_j_i;
		logic is_d;
		logic lt_8e;
		logic lt_a0;
		logic ge_e0;
		logic ge_f0;
		logic lt_41;
		logic lt_a1;
		logic gt_fc;
		logic le_a0;
		logic sjis_trail;
		logic euc_kanji;
		logic kana_trail;
	} byte_cls_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		byte_cls_t  cls;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] esc;
		logic       pend;
		verdict_t   sjis_v;
		logic [7:0] sjis_lead;
		logic       sjis_wait;
		verdict_t   euc_v;
		logic [1:0] euc_owed;
		logic [1:0] euc_class;
		logic [2:0] held;
	} scan_state_t;

	localparam scan_state_t SCAN_RESET = '{
		phase:     PH_PREFIX,
		esc:       ESC_NONE,
		pend:      1'b0,
		sjis_v:    V_MAYBE,
		sjis_lead: 8'h00,
		sjis_wait: 1'b0,
		euc_v:     V_MAYBE,
		euc_owed:  2'd0,
		euc_class: EUC_KANA,
		held:      CS_PLAIN
	};

endpackage
`default_nettype wire

// ===== sv/jcd_front.sv =====
`default_nettype none
module jcd_front (
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	output jcd_pkg::item_t item
);
	import jcd_pkg::*;

	logic [7:0] b;
	assign b = data_byte;

	always_comb begin
		item.data = b;
		item.last = last_byte;
		item.cls.hi         = b[7];
		item.cls.is_80      = (b == 8'h80);
		item.cls.is_8e      = (b == 8'h8E);
		item.cls.is_8f      = (b == 8'h8F);
		item.cls.is_a0      = (b == 8'hA0);
		item.cls.is_ff      = (b == 8'hFF);
		item.cls.is_esc     = (b == 8'h1B);
		item.cls.is_dollar  = (b == 8'h24);
		item.cls.is_paren   = (b == 8'h28);
		item.cls.is_b_at    = (b == 8'h42) || (b == 8'h40);
		item.cls.is_j_i     = (b == 8'h4A) || (b == 8'h49);
		item.cls.is_d       = (b == 8'h44);
		item.cls.lt_8e      = (b < 8'h8E);
		item.cls.lt_a0      = (b < 8'hA0);
		item.cls.ge_e0      = (b >= 8'hE0);
		item.cls.ge_f0      = (b >= 8'hF0);
		item.cls.lt_41      = (b < 8'h41);
		item.cls.lt_a1      = (b < 8'hA1);
		item.cls.gt_fc      = (b > 8'hFC);
		item.cls.le_a0      = (b <= 8'hA0);
		item.cls.sjis_trail = (b > 8'h3F) && (b < 8'hFD);
		item.cls.euc_kanji  = (b > 8'hA0) && (b < 8'hFF);
		item.cls.kana_trail = (b > 8'hA0) && (b < 8'hE0);
	end

endmodule
`default_nettype wire

// ===== sv/jcd_fifo.sv =====
`default_nettype none
module jcd_fifo #(
	parameter int Depth = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  jcd_pkg::item_t     wr_item,
	input  logic               pop,
	output jcd_pkg::item_t     rd_item,
	output jcd_pkg::fifo_stat_t stat
);
	import jcd_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	item_t            mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CntW'(Depth));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/jcd_back.sv =====
`default_nettype none
module jcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [1:0]          cfg_data,
	input  jcd_pkg::item_t      item,
	input  jcd_pkg::fifo_stat_t stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          charset
);
	import jcd_pkg::*;

	logic [1:0]  default_cs_q;
	logic        tie_pick_q;
	scan_state_t st_q;
	scan_state_t nx;
	logic [2:0]  cs_nx;
	logic [2:0]  charset_q;
	logic        out_valid_q;
	logic        run_range;
	logic        run_val;
	logic        slot_free;
	byte_cls_t   c;

	function automatic logic [2:0] combine(input verdict_t s, input verdict_t e,
			input logic [1:0] dcs, input logic tie);
		logic [2:0] r;
		if (dcs == DCS_SJIS) begin
			r = (e == V_YES) ? CS_EUC : CS_SJIS;
		end else if (dcs == DCS_EUC) begin
			r = (s == V_YES) ? CS_SJIS : CS_EUC;
		end else if (s == V_YES) begin
			r = CS_SJIS;
		end else if (e == V_YES) begin
			r = CS_EUC;
		end else if (s == V_NO) begin
			r = (e == V_NO) ? CS_PLAIN : CS_EUC;
		end else if (e == V_NO) begin
			r = CS_SJIS;
		end else begin
			r = tie ? CS_SJIS : CS_EUC;
		end
		return r;
	endfunction

	assign c         = item.cls;
	assign slot_free = !out_valid_q || !out_stall;
	// a non-final byte never touches the output slot
	assign pop       = !stat.empty && (!item.last || slot_free);
	assign out_valid = out_valid_q;
	assign charset   = charset_q;

	always_comb begin
		nx        = st_q;
		cs_nx     = CS_PLAIN;
		run_val   = (st_q.phase == PH_AMBIG);
		run_range = ((st_q.phase == PH_PREFIX) && c.hi) || (st_q.phase == PH_RANGE);

		if ((st_q.phase == PH_PREFIX) && !c.hi) begin
			if (((st_q.esc == ESC_DOLLAR) && c.is_b_at) ||
					((st_q.esc == ESC_PAREN) && c.is_j_i) ||
					((st_q.esc == ESC_DOLPAR) && c.is_d)) begin
				nx.held  = CS_JIS;
				nx.phase = PH_DECIDED;
			end else if (c.is_esc) begin
				nx.esc = ESC_ONE;
			end else if ((st_q.esc == ESC_ONE) && c.is_dollar) begin
				nx.esc = ESC_DOLLAR;
			end else if ((st_q.esc == ESC_ONE) && c.is_paren) begin
				nx.esc = ESC_PAREN;
			end else if ((st_q.esc == ESC_DOLLAR) && c.is_paren) begin
				nx.esc = ESC_DOLPAR;
			end else begin
				nx.esc = ESC_NONE;
			end
		end

		if (run_range) begin
			nx.phase = PH_RANGE;
			if (st_q.pend) begin
				// second byte after a 0xE0..0xEF lead
				nx.pend = 1'b0;
				if (c.lt_41) begin
					nx.held = CS_UNDECIDED; nx.phase = PH_DECIDED;
				end else if (c.lt_a1) begin
					nx.held = CS_SJIS; nx.phase = PH_DECIDED;
				end else if (c.gt_fc) begin
					nx.held = CS_EUC; nx.phase = PH_DECIDED;
				end
			end else if (c.hi) begin
				if (c.is_80 || c.is_a0 || c.is_ff) begin
					nx.held = CS_UNDECIDED; nx.phase = PH_DECIDED;
				end else if (c.lt_8e) begin
					nx.held = CS_SJIS; nx.phase = PH_DECIDED;
				end else if (c.ge_f0) begin
					nx.held = CS_EUC; nx.phase = PH_DECIDED;
				end else if (c.ge_e0) begin
					nx.pend = 1'b1;
				end else begin
					nx.phase = PH_AMBIG;
					run_val  = 1'b1;
				end
			end
		end

		if (run_val) begin
			if (st_q.sjis_v == V_MAYBE) begin
				if (st_q.sjis_wait) begin
					nx.sjis_wait = 1'b0;
					if (!c.sjis_trail) begin
						nx.sjis_v = V_NO;
					end else if ((st_q.sjis_lead < 8'hA0) &&
							(((st_q.sjis_lead != 8'h8E) && (st_q.sjis_lead != 8'h8F)) ||
							c.le_a0)) begin
						nx.sjis_v = V_YES;
					end
				end else if (c.hi) begin
					if (c.is_80) begin
						nx.sjis_v = V_NO;
					end else if (c.lt_a0 || (c.ge_e0 && !c.ge_f0)) begin
						nx.sjis_wait = 1'b1;
						nx.sjis_lead = item.data;
					end else if (c.ge_f0) begin
						nx.sjis_v = V_NO;
					end
				end
			end

			if (st_q.euc_v == V_MAYBE) begin
				if (st_q.euc_owed != 2'd0) begin
					if (st_q.euc_class == EUC_KANA) begin
						if (c.kana_trail) begin
							nx.euc_owed = 2'd0;
						end else begin
							nx.euc_v = V_NO;
						end
					end else if (!c.euc_kanji) begin
						nx.euc_v = V_NO;
					end else if (st_q.euc_class == EUC_ONLY) begin
						nx.euc_v = V_YES;
					end else begin
						nx.euc_owed = st_q.euc_owed - 2'd1;
					end
				end else if (c.hi) begin
					if (c.is_8e) begin
						nx.euc_owed  = 2'd1;
						nx.euc_class = EUC_KANA;
					end else if (c.is_8f) begin
						nx.euc_owed  = 2'd2;
						nx.euc_class = EUC_SS3;
					end else if (c.is_a0 || c.is_ff) begin
						nx.euc_v = V_NO;
					end else begin
						nx.euc_owed  = 2'd1;
						nx.euc_class = c.ge_f0 ? EUC_ONLY : EUC_PLAIN;
					end
				end
			end
		end

		if (item.last) begin
			if (nx.phase == PH_DECIDED) begin
				cs_nx = nx.held;
			end else if (nx.phase == PH_AMBIG) begin
				cs_nx = combine(nx.sjis_v, nx.euc_v, default_cs_q, tie_pick_q);
			end else begin
				cs_nx = CS_PLAIN;
			end
			nx = SCAN_RESET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_cs_q <= 2'd0;
			tie_pick_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEFAULT_CHARSET: default_cs_q <= cfg_data;
				CFG_TIE_PICK:        tie_pick_q   <= cfg_data[0];
				default:             ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= SCAN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				st_q <= nx;
			end
			if (pop && item.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			charset_q <= cs_nx;
		end
	end

endmodule
`default_nettype wire

// ===== sv/japanese_charset_detector_unit.sv =====
`default_nettype none
// Throughput: one byte per cycle; while a finished result waits on out_stall the
// queue still takes bytes until it holds QueueDepth of them, then in_stall rises.
// Result path: a final byte is written into the queue, read from it once it is at the
// head and the output slot is free, and its result lands in the output register (out_valid).
// Reset (arst_n low): scan state back to the 7-bit prefix phase, queue empty,
// output invalid, both configuration registers zero.
module japanese_charset_detector_unit #(
	parameter int QueueDepth = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] charset
);
	import jcd_pkg::*;

	item_t      front_item;
	item_t      head_item;
	fifo_stat_t stat;
	logic       pop;

	jcd_front u_front (
		.data_byte (data_byte),
		.last_byte (last_byte),
		.item      (front_item)
	);

	jcd_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_valid),
		.wr_item (front_item),
		.pop     (pop),
		.rd_item (head_item),
		.stat    (stat)
	);

	assign in_stall = stat.full;

	jcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (head_item),
		.stat      (stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.charset   (charset)
	);

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !stat.empty)
		else $error("queue full and empty at once");

	a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && stat.empty) |=> !out_valid)
		else $error("result appeared with no byte queued");

	a_charset_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (charset <= CS_UNDECIDED))
		else $error("charset code out of range");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("pop from empty queue");

endmodule
`default_nettype wire
